/* src/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the set-associative cache tag lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

    localparam int DEF_SETS       = 64;
    localparam int DEF_WAYS       = 4;
    localparam int DEF_LINE_BYTES = 64;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam int IN_ADDR_W   = 32;
    localparam int CNT_W       = 32;
    localparam int USE_W       = 16;
    localparam int MODE_W      = 2;
    localparam int OUT_WAY_W   = 2;
    localparam int WAY_FIELD_W = 4;
    localparam int LFSR_W      = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [USE_W-1:0]  USE_MAX   = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

    localparam logic [MODE_W-1:0] MODE_LRU  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LFU  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RAND = 2'd2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic                   hit;
        logic [WAY_FIELD_W-1:0] hit_way;
        logic                   inv_found;
        logic [WAY_FIELD_W-1:0] inv_way;
        logic                   lru_found;
        logic [WAY_FIELD_W-1:0] lru_way;
        logic [WAY_FIELD_W-1:0] lfu_way;
    } t_scan_res;

endpackage

`default_nettype wire

/* src/sacl_set_mem.sv */
// ----------------------------------------------------------------------------
// sacl_set_mem
// Set memory: one row per set, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_set_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/sacl_way_scan.sv */
// ----------------------------------------------------------------------------
// sacl_way_scan
// Shared per-way compare unit: looks at one way of the set per cycle while i_step
// is high and accumulates hit, first invalid, LRU and LFU candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_way_scan #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 20,
    parameter int WIW   = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [WIW-1:0]             i_way_idx,
    input  wire logic                       i_valid_bit,
    input  wire logic [TAG_W-1:0]           i_tag,
    input  wire logic [TAG_W-1:0]           i_lookup_tag,
    input  wire logic [sacl_pkg::USE_W-1:0] i_use,
    input  wire logic [WIW-1:0]             i_rank,
    output sacl_pkg::t_scan_res             o_res
);

    sacl_pkg::t_scan_res            r_res;
    sacl_pkg::t_scan_res            n_res;
    logic [sacl_pkg::USE_W-1:0]     r_best_use;
    logic [sacl_pkg::USE_W-1:0]     n_best_use;
    logic                           first;
    logic [sacl_pkg::WAY_FIELD_W-1:0] idx_ext;

    always_comb begin
        first      = (i_way_idx == '0);
        idx_ext    = sacl_pkg::WAY_FIELD_W'(i_way_idx);
        n_res      = r_res;
        n_best_use = r_best_use;
        if (first) begin
            n_res.hit       = 1'b0;
            n_res.inv_found = 1'b0;
            n_res.lru_found = 1'b0;
        end
        if (!n_res.hit && i_valid_bit && (i_tag == i_lookup_tag)) begin
            n_res.hit     = 1'b1;
            n_res.hit_way = idx_ext;
        end
        if (!n_res.inv_found && !i_valid_bit) begin
            n_res.inv_found = 1'b1;
            n_res.inv_way   = idx_ext;
        end
        if (!n_res.lru_found && (i_rank == WIW'(WAYS - 1))) begin
            n_res.lru_found = 1'b1;
            n_res.lru_way   = idx_ext;
        end
        if (first || (i_use < r_best_use)) begin
            n_res.lfu_way = idx_ext;
            n_best_use    = i_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.hit       <= 1'b0;
            r_res.inv_found <= 1'b0;
            r_res.lru_found <= 1'b0;
        end else if (i_step) begin
            r_res      <= n_res;
            r_best_use <= n_best_use;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* src/set_assoc_cache_tag_lookup.sv */
// After a request is accepted, the set row is read, the shared per-way compare
// unit steps through the ways of the set one per cycle, and the update step then
// writes the row back and registers the result. One request at a time: no new
// request is taken until the update step is done. A pending result that is not taken holds the update step.
// Reset: a clearing pass writes every one of the 2^floor(log2(SETS)) set rows
// (64 by default), with request ready low; configuration writes are taken.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Set-associative tag lookup with LRU, LFU or pseudo-random replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_tag_lookup #(
    parameter int SETS       = sacl_pkg::DEF_SETS,
    parameter int WAYS       = sacl_pkg::DEF_WAYS,
    parameter int LINE_BYTES = sacl_pkg::DEF_LINE_BYTES,
    parameter int ADDR_WIDTH = sacl_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [sacl_pkg::MODE_W-1:0]      i_cfg_wr_data,
    input  wire logic                             i_req_valid,
    output logic                                  o_req_ready,
    input  wire logic                             i_opcode,
    input  wire logic [sacl_pkg::IN_ADDR_W-1:0]   i_address,
    output logic                                  o_rsp_valid,
    input  wire logic                             i_rsp_ready,
    output logic                                  o_hit,
    output logic [sacl_pkg::OUT_WAY_W-1:0]        o_way,
    output logic                                  o_victim_valid,
    output logic                                  o_victim_dirty,
    output logic [sacl_pkg::IN_ADDR_W-1:0]        o_victim_address,
    output logic [sacl_pkg::CNT_W-1:0]            o_hit_total,
    output logic [sacl_pkg::CNT_W-1:0]            o_miss_total
);

    localparam int AW     = sacl_pkg::IN_ADDR_W;
    localparam int OB     = $clog2(LINE_BYTES + 1) - 1;
    localparam int SB     = $clog2(SETS + 1) - 1;
    localparam int EAW    = (ADDR_WIDTH < AW) ? ADDR_WIDTH : AW;
    localparam int TW_RAW = EAW - OB - SB;
    localparam int TW     = (TW_RAW < 1) ? 1 : TW_RAW;
    localparam int WIW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int UW     = sacl_pkg::USE_W;
    localparam int EW     = 2 + WIW + UW + TW;
    localparam int ROWS   = 1 << SB;
    localparam int RW_W   = WAYS * EW;
    localparam int LW     = sacl_pkg::LFSR_W;
    localparam int PW     = LW + 33;
    localparam logic [32:0] RAND_M = 33'((64'd1 << 32) / WAYS);
    localparam logic [AW-1:0] ADDR_MASK = AW'((64'd1 << EAW) - 64'd1);

    // entry layout: {valid, dirty, rank, use, tag}
    localparam int TAG_LO   = 0;
    localparam int USE_LO   = TW;
    localparam int RANK_LO  = TW + UW;
    localparam int DIRTY_B  = TW + UW + WIW;
    localparam int VALID_B  = TW + UW + WIW + 1;

    sacl_pkg::t_state r_state;
    sacl_pkg::t_state n_state;

    logic [SB-1:0]                 r_clr_idx;
    logic [WIW-1:0]                r_scan_idx;
    logic [sacl_pkg::MODE_W-1:0]   r_mode;
    logic [LW-1:0]                 r_lfsr;
    logic [PW-1:0]                 r_rnd_prod;
    logic [WIW-1:0]                r_rnd_rem;
    logic [sacl_pkg::CNT_W-1:0]    r_hit_cnt;
    logic [sacl_pkg::CNT_W-1:0]    r_miss_cnt;
    logic                          r_rsp_valid;
    logic [SB-1:0]                 r_set;
    logic [TW-1:0]                 r_tag;
    logic                          r_write;

    logic                          req_fire;
    logic                          upd_fire;
    logic [AW-1:0]                 addr_m;
    logic [SB-1:0]                 in_set;
    logic [TW-1:0]                 in_tag;

    logic                          mem_we;
    logic [SB-1:0]                 mem_waddr;
    logic [RW_W-1:0]               mem_wdata;
    logic [RW_W-1:0]               rd_row;
    logic [RW_W-1:0]               clr_row;
    logic [RW_W-1:0]               upd_row;

    logic [EW-1:0]                 e_row   [WAYS];
    logic                          e_dirty [WAYS];
    logic [WIW-1:0]                e_rank  [WAYS];
    logic [UW-1:0]                 e_use   [WAYS];
    logic [TW-1:0]                 e_tag   [WAYS];
    logic [EW-1:0]                 cur_ent;

    sacl_pkg::t_scan_res           scan_res;

    logic [LW-1:0]                 rnd_next;
    logic [LW-1:0]                 rnd_q;
    logic [LW+4:0]                 rnd_diff;
    logic                          miss;
    logic                          full;
    logic                          vic;
    logic [WIW-1:0]                vic_way;
    logic [WIW-1:0]                way_sel;
    logic [sacl_pkg::WAY_FIELD_W-1:0] way_ext;
    logic [WIW-1:0]                sel_rank;
    logic [EW-1:0]                 new_ent;
    logic [AW-1:0]                 vic_addr;

    assign req_fire    = i_req_valid && o_req_ready;
    assign upd_fire    = (r_state == sacl_pkg::S_UPDATE) && (!r_rsp_valid || i_rsp_ready);
    assign o_req_ready = (r_state == sacl_pkg::S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_hit_total  = r_hit_cnt;
    assign o_miss_total = r_miss_cnt;

    assign addr_m = i_address & ADDR_MASK;
    assign in_set = SB'(addr_m >> OB);
    assign in_tag = TW'(addr_m >> (OB + SB));

    // unpack the row read from the set memory
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            e_row[w]   = rd_row[w*EW +: EW];
            e_tag[w]   = e_row[w][TAG_LO +: TW];
            e_use[w]   = e_row[w][USE_LO +: UW];
            e_rank[w]  = e_row[w][RANK_LO +: WIW];
            e_dirty[w] = e_row[w][DIRTY_B];
        end
        cur_ent = e_row[r_scan_idx];
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            clr_row[w*EW +: EW] = {1'b0, 1'b0, WIW'(w), UW'(0), TW'(0)};
        end
    end

    // pseudo-random victim: next LFSR value modulo WAYS, via reciprocal
    assign rnd_next = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[LW-1:1]};
    assign rnd_q    = LW'(r_rnd_prod >> 32);
    assign rnd_diff = (LW+5)'(rnd_next) - (LW+5)'(rnd_q) * (LW+5)'(WAYS);

    always_ff @(posedge i_clk) begin
        r_rnd_prod <= PW'(rnd_next) * PW'(RAND_M);
        if (rnd_diff >= (LW+5)'(WAYS)) begin
            r_rnd_rem <= WIW'(rnd_diff - (LW+5)'(WAYS));
        end else begin
            r_rnd_rem <= WIW'(rnd_diff);
        end
    end

    // update decision and new row contents
    always_comb begin
        miss = !scan_res.hit;
        full = !scan_res.inv_found;
        vic  = miss && full;
        priority if (r_mode == sacl_pkg::MODE_LFU) begin
            vic_way = WIW'(scan_res.lfu_way);
        end else if (r_mode == sacl_pkg::MODE_RAND) begin
            vic_way = r_rnd_rem;
        end else if (scan_res.lru_found) begin
            vic_way = WIW'(scan_res.lru_way);
        end else begin
            vic_way = '0;
        end
        priority if (scan_res.hit) begin
            way_sel = WIW'(scan_res.hit_way);
        end else if (scan_res.inv_found) begin
            way_sel = WIW'(scan_res.inv_way);
        end else begin
            way_sel = vic_way;
        end
        way_ext  = sacl_pkg::WAY_FIELD_W'(way_sel);
        sel_rank = e_rank[way_sel];
        vic_addr = AW'((64'(e_tag[way_sel]) << (OB + SB)) | (64'(r_set) << OB));
        new_ent  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (WIW'(w) == way_sel) begin
                new_ent[TAG_LO +: TW]    = miss ? r_tag : e_tag[w];
                new_ent[USE_LO +: UW]    = (e_use[w] == sacl_pkg::USE_MAX) ?
                                           e_use[w] : e_use[w] + UW'(1);
                new_ent[RANK_LO +: WIW]  = '0;
                new_ent[DIRTY_B]         = (r_write == sacl_pkg::OP_WRITE) ||
                                           (!miss && e_dirty[w]);
                new_ent[VALID_B]         = 1'b1;
                upd_row[w*EW +: EW]      = new_ent;
            end else if (e_rank[w] < sel_rank) begin
                upd_row[w*EW +: EW]      = e_row[w];
                upd_row[w*EW + RANK_LO +: WIW] = e_rank[w] + WIW'(1);
            end else begin
                upd_row[w*EW +: EW]      = e_row[w];
            end
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_set;
        mem_wdata = upd_row;
        if (r_state == sacl_pkg::S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_idx;
            mem_wdata = clr_row;
        end else if (upd_fire) begin
            mem_we = 1'b1;
        end
    end

    sacl_set_mem #(
        .DEPTH (ROWS),
        .WIDTH (RW_W),
        .AW    (SB)
    ) u_set_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (mem_wdata),
        .i_rd_en   (req_fire),
        .i_rd_addr (in_set),
        .o_rd_data (rd_row)
    );

    sacl_way_scan #(
        .WAYS  (WAYS),
        .TAG_W (TW),
        .WIW   (WIW)
    ) u_way_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (r_state == sacl_pkg::S_SCAN),
        .i_way_idx    (r_scan_idx),
        .i_valid_bit  (cur_ent[VALID_B]),
        .i_tag        (cur_ent[TAG_LO +: TW]),
        .i_lookup_tag (r_tag),
        .i_use        (cur_ent[USE_LO +: UW]),
        .i_rank       (cur_ent[RANK_LO +: WIW]),
        .o_res        (scan_res)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sacl_pkg::S_CLEAR: begin
                if (r_clr_idx == SB'(ROWS - 1)) begin
                    n_state = sacl_pkg::S_IDLE;
                end
            end
            sacl_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_state = sacl_pkg::S_SCAN;
                end
            end
            sacl_pkg::S_SCAN: begin
                if (r_scan_idx == WIW'(WAYS - 1)) begin
                    n_state = sacl_pkg::S_UPDATE;
                end
            end
            sacl_pkg::S_UPDATE: begin
                if (upd_fire) begin
                    n_state = sacl_pkg::S_IDLE;
                end
            end
            default: n_state = sacl_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacl_pkg::S_CLEAR;
            r_clr_idx   <= '0;
            r_scan_idx  <= '0;
            r_mode      <= sacl_pkg::MODE_LRU;
            r_lfsr      <= sacl_pkg::LFSR_SEED;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (r_state == sacl_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + SB'(1);
            end
            if (r_state == sacl_pkg::S_SCAN) begin
                r_scan_idx <= (r_scan_idx == WIW'(WAYS - 1)) ? '0 : r_scan_idx + WIW'(1);
            end
            if (upd_fire) begin
                r_rsp_valid <= 1'b1;
                if (miss) begin
                    if (r_miss_cnt != sacl_pkg::CNT_MAX) begin
                        r_miss_cnt <= r_miss_cnt + sacl_pkg::CNT_W'(1);
                    end
                end else if (r_hit_cnt != sacl_pkg::CNT_MAX) begin
                    r_hit_cnt <= r_hit_cnt + sacl_pkg::CNT_W'(1);
                end
                if (vic && (r_mode == sacl_pkg::MODE_RAND)) begin
                    r_lfsr <= rnd_next;
                end
            end else if (o_rsp_valid && i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_set   <= in_set;
            r_tag   <= in_tag;
            r_write <= i_opcode;
        end
        if (upd_fire) begin
            o_hit            <= !miss;
            o_way            <= way_ext[sacl_pkg::OUT_WAY_W-1:0];
            o_victim_valid   <= vic;
            o_victim_dirty   <= vic && e_dirty[way_sel];
            o_victim_address <= vic ? vic_addr : '0;
        end
    end

    a_no_hit_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !(o_hit && o_victim_valid))
        else $error("hit reported with a victim");

    a_dirty_needs_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_victim_dirty) |-> o_victim_valid)
        else $error("dirty victim without valid victim");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> !o_req_ready)
        else $error("ready right after accepting a request");

    a_cnt_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_hit_cnt != $past(r_hit_cnt)) || (r_miss_cnt != $past(r_miss_cnt)))
        |-> $past(upd_fire))
        else $error("totals changed outside the update step");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative tag lookup. A scoreboard
// class keeps its own tag store, ranks, use counts and LFSR, predicts
// every response and checks it in order. The stimulus is directed fills,
// hits and evictions first. Random phases follow in each replacement mode,
// on hot sets and a small tag pool. Both handshakes get random stalls,
// one long response hold and several full drains.
// ----------------------------------------------------------------------------

localparam int N_SETS = sacl_pkg::DEF_SETS;
localparam int N_WAYS = sacl_pkg::DEF_WAYS;
localparam int OFF_W  = $clog2(sacl_pkg::DEF_LINE_BYTES);
localparam int SET_W  = $clog2(N_SETS);
localparam int TAG_W  = sacl_pkg::IN_ADDR_W - OFF_W - SET_W;

localparam logic [sacl_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

typedef struct packed {
    logic                              hit;
    logic [sacl_pkg::OUT_WAY_W-1:0]    way;
    logic                              victim_valid;
    logic                              victim_dirty;
    logic [sacl_pkg::IN_ADDR_W-1:0]    victim_address;
    logic [sacl_pkg::CNT_W-1:0]        hit_total;
    logic [sacl_pkg::CNT_W-1:0]        miss_total;
} lookup_rsp_t;

class lookup_scoreboard;
    logic [TAG_W-1:0]             tag_mem   [N_SETS][N_WAYS];
    bit                           valid_mem [N_SETS][N_WAYS];
    bit                           dirty_mem [N_SETS][N_WAYS];
    int unsigned                  rank_mem  [N_SETS][N_WAYS];
    bit [sacl_pkg::USE_W-1:0]     use_mem   [N_SETS][N_WAYS];
    bit [sacl_pkg::LFSR_W-1:0]    lfsr;
    bit [sacl_pkg::CNT_W-1:0]     hit_cnt;
    bit [sacl_pkg::CNT_W-1:0]     miss_cnt;
    logic [sacl_pkg::MODE_W-1:0]  mode;
    lookup_rsp_t                  rsp_q[$];
    int errors;
    int n_req;
    int n_hit;
    int n_evict;
    int n_dirty_evict;
    int n_checked;

    function new();
        foreach (rank_mem[s, w]) begin
            tag_mem[s][w]   = '0;
            valid_mem[s][w] = 1'b0;
            dirty_mem[s][w] = 1'b0;
            rank_mem[s][w]  = w;
            use_mem[s][w]   = '0;
        end
        lfsr          = sacl_pkg::LFSR_SEED;
        hit_cnt       = '0;
        miss_cnt      = '0;
        mode          = sacl_pkg::MODE_LRU;
        errors        = 0;
        n_req         = 0;
        n_hit         = 0;
        n_evict       = 0;
        n_dirty_evict = 0;
        n_checked     = 0;
    endfunction

    function void set_mode(logic [sacl_pkg::MODE_W-1:0] m);
        mode = m;
    endfunction

    function int pending();
        return rsp_q.size();
    endfunction

    function int pick_victim(int s);
        int  victim;
        bit  fb;
        victim = 0;
        case (mode)
            sacl_pkg::MODE_LFU: begin
                for (int w = 1; w < N_WAYS; w++)
                    if (use_mem[s][w] < use_mem[s][victim])
                        victim = w;
            end
            sacl_pkg::MODE_RAND: begin
                fb     = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
                lfsr   = {fb, lfsr[sacl_pkg::LFSR_W-1:1]};
                victim = int'(lfsr) % N_WAYS;
            end
            default: begin
                // LRU, also taken by the spare mode code
                for (int w = N_WAYS - 1; w >= 0; w--)
                    if (rank_mem[s][w] == N_WAYS - 1)
                        victim = w;
            end
        endcase
        return victim;
    endfunction

    function void note_request(logic op, logic [sacl_pkg::IN_ADDR_W-1:0] addr);
        lookup_rsp_t       r;
        logic [SET_W-1:0]  set_idx;
        logic [TAG_W-1:0]  tag;
        int                s;
        int                way;
        int unsigned       rk;
        bit                found;
        r       = '0;
        set_idx = addr[OFF_W +: SET_W];
        tag     = addr[sacl_pkg::IN_ADDR_W-1 -: TAG_W];
        s       = int'(set_idx);
        way     = 0;
        found   = 1'b0;
        for (int w = 0; w < N_WAYS; w++)
            if (!found && valid_mem[s][w] && tag_mem[s][w] == tag) begin
                found = 1'b1;
                way   = w;
            end
        r.hit = found;
        if (found) begin
            if (hit_cnt != sacl_pkg::CNT_MAX)
                hit_cnt++;
            n_hit++;
        end else begin
            if (miss_cnt != sacl_pkg::CNT_MAX)
                miss_cnt++;
            for (int w = 0; w < N_WAYS; w++)
                if (!found && !valid_mem[s][w]) begin
                    found = 1'b1;
                    way   = w;
                end
            if (!found) begin
                way                = pick_victim(s);
                r.victim_valid     = 1'b1;
                r.victim_dirty     = dirty_mem[s][way];
                r.victim_address   = {tag_mem[s][way], set_idx, {OFF_W{1'b0}}};
                n_evict++;
                if (dirty_mem[s][way])
                    n_dirty_evict++;
            end
            tag_mem[s][way]   = tag;
            valid_mem[s][way] = 1'b1;
            dirty_mem[s][way] = 1'b0;
        end
        if (op == sacl_pkg::OP_WRITE)
            dirty_mem[s][way] = 1'b1;
        rk = rank_mem[s][way];
        for (int w = 0; w < N_WAYS; w++)
            if (rank_mem[s][w] < rk)
                rank_mem[s][w]++;
        rank_mem[s][way] = 0;
        if (use_mem[s][way] != sacl_pkg::USE_MAX)
            use_mem[s][way]++;
        r.way        = sacl_pkg::OUT_WAY_W'(way);
        r.hit_total  = hit_cnt;
        r.miss_total = miss_cnt;
        rsp_q.push_back(r);
        n_req++;
    endfunction

    function void check_response(lookup_rsp_t got);
        lookup_rsp_t e;
        if (rsp_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: response with no request outstanding", $time);
            return;
        end
        e = rsp_q.pop_front();
        n_checked++;
        if (got !== e) begin
            errors++;
            if (errors <= 10) begin
                $display("%0t: mismatch exp hit=%0d way=%0d vv=%0d vd=%0d va=%h ht=%0d mt=%0d",
                         $time, e.hit, e.way, e.victim_valid, e.victim_dirty,
                         e.victim_address, e.hit_total, e.miss_total);
                $display("%0t:          got hit=%0d way=%0d vv=%0d vd=%0d va=%h ht=%0d mt=%0d",
                         $time, got.hit, got.way, got.victim_valid, got.victim_dirty,
                         got.victim_address, got.hit_total, got.miss_total);
            end
        end
    endfunction
endclass

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RSP_HOLD       = 300;
    localparam int SETTLE_CYCLES  = N_WAYS + 4;
    localparam int POOL_N         = 6;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_wr_en;
    logic [sacl_pkg::MODE_W-1:0]        i_cfg_wr_data;
    logic                               i_req_valid;
    logic                               o_req_ready;
    logic                               i_opcode;
    logic [sacl_pkg::IN_ADDR_W-1:0]     i_address;
    logic                               o_rsp_valid;
    logic                               i_rsp_ready;
    logic                               o_hit;
    logic [sacl_pkg::OUT_WAY_W-1:0]     o_way;
    logic                               o_victim_valid;
    logic                               o_victim_dirty;
    logic [sacl_pkg::IN_ADDR_W-1:0]     o_victim_address;
    logic [sacl_pkg::CNT_W-1:0]         o_hit_total;
    logic [sacl_pkg::CNT_W-1:0]         o_miss_total;

    lookup_scoreboard  sb;
    bit                idle_on;
    bit                hold_rsp;
    int                idle_cycles;
    logic [TAG_W-1:0]  tag_pool [POOL_N];
    logic [SET_W-1:0]  hot_sets [4];

    set_assoc_cache_tag_lookup dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_req_valid      (i_req_valid),
        .o_req_ready      (o_req_ready),
        .i_opcode         (i_opcode),
        .i_address        (i_address),
        .o_rsp_valid      (o_rsp_valid),
        .i_rsp_ready      (i_rsp_ready),
        .o_hit            (o_hit),
        .o_way            (o_way),
        .o_victim_valid   (o_victim_valid),
        .o_victim_dirty   (o_victim_dirty),
        .o_victim_address (o_victim_address),
        .o_hit_total      (o_hit_total),
        .o_miss_total     (o_miss_total)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // handshake monitor and watchdog
    always @(posedge i_clk) begin
        lookup_rsp_t got;
        bit          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_req_valid && o_req_ready) begin
                sb.note_request(i_opcode, i_address);
                moved = 1'b1;
            end
            if (o_rsp_valid && i_rsp_ready) begin
                got.hit            = o_hit;
                got.way            = o_way;
                got.victim_valid   = o_victim_valid;
                got.victim_dirty   = o_victim_dirty;
                got.victim_address = o_victim_address;
                got.hit_total      = o_hit_total;
                got.miss_total     = o_miss_total;
                sb.check_response(got);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // response side: random stalls, plus one long hold on request
    initial begin : rsp_side
        int n;
        i_rsp_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                i_rsp_ready = 1'b0;
                repeat (RSP_HOLD) @(negedge i_clk);
                hold_rsp    = 1'b0;
                i_rsp_ready = 1'b1;
            end else if (idle_on && $urandom_range(0, 99) < 30) begin
                i_rsp_ready = 1'b0;
                n = pick_gap();
                repeat (n) @(negedge i_clk);
            end else begin
                i_rsp_ready = 1'b1;
            end
        end
    end

    function automatic logic [sacl_pkg::IN_ADDR_W-1:0] mk_addr(
        logic [TAG_W-1:0] t, logic [SET_W-1:0] s, logic [OFF_W-1:0] o);
        return {t, s, o};
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(logic op, logic [sacl_pkg::IN_ADDR_W-1:0] addr);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_req_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode    = op;
        i_address   = addr;
        i_req_valid = 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        @(negedge i_clk);
    endtask

    task automatic send_random();
        int                r;
        logic              op;
        logic [SET_W-1:0]  s;
        r  = $urandom_range(0, 99);
        op = 1'($urandom_range(0, 1));
        if (r < 10) begin
            send_req(op, $urandom);
        end else begin
            s = (r < 75) ? hot_sets[$urandom_range(0, 3)] :
                           SET_W'($urandom_range(0, N_SETS - 1));
            send_req(op, mk_addr(tag_pool[$urandom_range(0, POOL_N - 1)], s,
                                 OFF_W'($urandom_range(0, (1 << OFF_W) - 1))));
        end
    endtask

    // more tags than ways into one set, with a few re-touches
    task automatic conflict_burst(logic [SET_W-1:0] s);
        for (int i = 0; i < POOL_N; i++)
            send_req((i % 2) ? sacl_pkg::OP_WRITE : sacl_pkg::OP_READ, mk_addr(tag_pool[i], s, 0));
        send_req(sacl_pkg::OP_READ, mk_addr(tag_pool[POOL_N - 1], s, 0));
        send_req(sacl_pkg::OP_WRITE, mk_addr(tag_pool[0], s, 0));
        send_req(sacl_pkg::OP_READ, mk_addr(tag_pool[2], s, 0));
    endtask

    task automatic new_hot_sets();
        foreach (hot_sets[i])
            hot_sets[i] = SET_W'($urandom_range(0, N_SETS - 1));
        for (int i = 2; i < POOL_N; i++)
            tag_pool[i] = TAG_W'($urandom);
    endtask

    task automatic drain();
        i_req_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(logic [sacl_pkg::MODE_W-1:0] m);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = m;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.set_mode(m);
    endtask

    initial begin : stimulus
        sb            = new();
        idle_cycles   = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = sacl_pkg::MODE_LRU;
        i_req_valid   = 1'b0;
        i_opcode      = sacl_pkg::OP_READ;
        i_address     = '0;
        idle_on       = 1'b0;
        hold_rsp      = 1'b0;
        tag_pool[0]   = '0;
        tag_pool[1]   = '1;
        new_hot_sets();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_mode(sacl_pkg::MODE_LRU);

        // directed: fills, hits, dirty and clean LRU evictions, field extremes
        send_req(sacl_pkg::OP_READ,  32'h0000_0000);
        send_req(sacl_pkg::OP_WRITE, 32'hFFFF_FFFF);
        send_req(sacl_pkg::OP_READ,  mk_addr(0, 0, '1));
        send_req(sacl_pkg::OP_WRITE, mk_addr(0, 0, 5));
        send_req(sacl_pkg::OP_READ,  mk_addr(1, 0, 0));
        send_req(sacl_pkg::OP_WRITE, mk_addr(2, 0, 0));
        send_req(sacl_pkg::OP_READ,  mk_addr(3, 0, 0));
        send_req(sacl_pkg::OP_READ,  mk_addr(1, 0, 9));
        send_req(sacl_pkg::OP_READ,  mk_addr(4, 0, 0));
        send_req(sacl_pkg::OP_READ,  mk_addr(5, 0, 0));
        send_req(sacl_pkg::OP_WRITE, mk_addr('1, 0, 0));
        send_req(sacl_pkg::OP_READ,  mk_addr(0, 0, 0));
        send_req(sacl_pkg::OP_READ,  mk_addr(20'h80000, '1, 0));
        send_req(sacl_pkg::OP_WRITE, mk_addr(20'h7FFFF, '1, 0));
        send_req(sacl_pkg::OP_READ,  mk_addr(20'h00001, '1, 0));
        send_req(sacl_pkg::OP_READ,  mk_addr(20'h55555, '1, 0));

        idle_on = 1'b1;
        conflict_burst(hot_sets[0]);
        repeat (240) send_random();

        // LFU, starting under a long response hold with back-to-back requests
        drain();
        write_mode(sacl_pkg::MODE_LFU);
        new_hot_sets();
        idle_on  = 1'b0;
        hold_rsp = 1'b1;
        repeat (30) send_random();
        idle_on = 1'b1;
        conflict_burst(hot_sets[1]);
        repeat (210) send_random();

        // pseudo-random, no stalls on either side
        drain();
        write_mode(sacl_pkg::MODE_RAND);
        new_hot_sets();
        idle_on = 1'b0;
        conflict_burst(hot_sets[2]);
        repeat (240) send_random();

        drain();
        write_mode(MODE_SPARE);
        new_hot_sets();
        idle_on = 1'b1;
        conflict_burst(hot_sets[3]);
        repeat (240) send_random();

        // back to LRU, with a full drain halfway
        drain();
        write_mode(sacl_pkg::MODE_LRU);
        new_hot_sets();
        conflict_burst(hot_sets[0]);
        repeat (120) send_random();
        i_req_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (120) send_random();
        drain();

        $display("Ran %0d requests over LRU, LFU, random and spare modes, %0d responses checked.",
                 sb.n_req, sb.n_checked);
        $display("Saw %0d hits, %0d evictions (%0d dirty), %0d mismatches.",
                 sb.n_hit, sb.n_evict, sb.n_dirty_evict, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
src/sacl_pkg.sv
src/sacl_set_mem.sv
src/sacl_way_scan.sv
src/set_assoc_cache_tag_lookup.sv
tb/tb_top.sv
